### sv/lrst_pkg.sv
// Shared types, constants and helpers for the light ramp schedule thermostat.
// No dependencies; imported by lrst_interp and light_ramp_schedule_thermostat.
`timescale 1ns / 1ps

package lrst_pkg;

  localparam int MAX_ENTRIES  = 16;
  localparam int HYST_STEPS   = 8;
  localparam int MIN_PER_HOUR = 60;
  localparam int MIN_PER_DAY  = 24 * 60;
  localparam int LEVEL_MAX    = 100;

  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int TIME_W  = 11;
  localparam int SPAN_W  = 13;
  localparam int PCT_W   = 7;
  localparam int PROD_W  = 22;
  localparam int QUOT_W  = 7;
  localparam int K_W     = $clog2(QUOT_W);
  localparam int TEMP_W  = 12;
  localparam int TEMPX_W = 14;
  localparam int CFG_W   = 12;

  localparam logic [1:0] FUNC_EVAL   = 2'd0;
  localparam logic [1:0] FUNC_BUTTON = 2'd1;
  localparam logic [1:0] FUNC_WRITE  = 2'd2;

  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_AUTO = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;

  localparam logic CFG_ENTRY_COUNT   = 1'b0;
  localparam logic CFG_TEMP_SETPOINT = 1'b1;

  typedef struct packed {
    logic [1:0]               func;
    logic [4:0]               hour;
    logic [5:0]               minute;
    logic signed [TEMP_W-1:0] temperature;
    logic                     sensor_disconnected;
    logic [3:0]               entry_index;
    logic [4:0]               entry_hour;
    logic [5:0]               entry_minute;
    logic [6:0]               entry_percent;
  } item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] light_percent;
    logic       pump_on;
    logic       heater_on;
  } result_t;

  typedef struct packed {
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [PCT_W-1:0] percent;
  } sched_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] t_prev;
    logic [PCT_W-1:0]  p_prev;
    logic [TIME_W-1:0] t_next;
    logic [PCT_W-1:0]  p_next;
  } interp_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_START,
    ST_INTERP,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    IP_IDLE,
    IP_SPAN,
    IP_MUL,
    IP_SUM,
    IP_RANGE,
    IP_DIV,
    IP_FIN
  } ip_state_t;

  // minutes of day: 60*h = 64*h - 4*h
  function automatic logic [TIME_W-1:0] point_time(input logic [4:0] h,
                                                   input logic [5:0] m);
    logic [TIME_W-1:0] hx;
    hx = TIME_W'(h);
    return (hx << 6) - (hx << 2) + TIME_W'(m);
  endfunction

endpackage

### sv/lrst_interp.sv
// Brightness interpolation between two schedule points: span, products,
// then a restoring divide one quotient bit per cycle. Uses lrst_pkg.
`timescale 1ns / 1ps

module lrst_interp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  lrst_pkg::interp_req_t     req,
  output logic                      done,
  output logic [lrst_pkg::PCT_W-1:0] level
);
  import lrst_pkg::*;

  ip_state_t state, state_next;

  interp_req_t              req_r;
  logic signed [SPAN_W-1:0] num, den;
  logic signed [PROD_W-1:0] prod_a, prod_b, rem, den_x, trial;
  logic [K_W-1:0]           k;
  logic [QUOT_W-1:0]        q;

  logic signed [SPAN_W-1:0] now_s, tp_s, tn_s, day_s;
  logic signed [SPAN_W-1:0] num_next, den_next;
  logic signed [PCT_W:0]    pp_s, pn_s, diff_s;
  logic                     den_pos, rem_neg, rem_over, fit;
  logic                     done_next;
  logic [PCT_W-1:0]         level_next, pp_sat, q_sat;

  always_comb begin
    now_s = $signed({2'b00, req_r.now});
    tp_s  = $signed({2'b00, req_r.t_prev});
    tn_s  = $signed({2'b00, req_r.t_next});
    day_s = SPAN_W'(MIN_PER_DAY);
    if (req_r.t_next >= req_r.t_prev) begin
      den_next = tn_s - tp_s;
      num_next = now_s - tp_s;
    end else begin
      den_next = tn_s + day_s - tp_s;
      num_next = (req_r.now >= req_r.t_prev) ? now_s - tp_s : now_s + day_s - tp_s;
    end
    pp_s     = $signed({1'b0, req_r.p_prev});
    pn_s     = $signed({1'b0, req_r.p_next});
    diff_s   = pn_s - pp_s;
    den_x    = PROD_W'(den);
    trial    = den_x <<< k;
    den_pos  = den > 0;
    rem_neg  = rem < 0;
    rem_over = rem >= (den_x <<< QUOT_W);
    fit      = rem >= trial;
    pp_sat   = (req_r.p_prev > PCT_W'(LEVEL_MAX)) ? PCT_W'(LEVEL_MAX) : req_r.p_prev;
    q_sat    = (q > QUOT_W'(LEVEL_MAX)) ? PCT_W'(LEVEL_MAX) : PCT_W'(q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IP_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    level_next = level;
    case (state)
      IP_IDLE:  if (start) state_next = IP_SPAN;
      IP_SPAN:  state_next = IP_MUL;
      IP_MUL: begin
        if (den_pos) begin
          state_next = IP_SUM;
        end else begin
          state_next = IP_IDLE;
          done_next  = 1'b1;
          level_next = pp_sat;
        end
      end
      IP_SUM:   state_next = IP_RANGE;
      IP_RANGE: begin
        if (rem_neg || rem_over) begin
          state_next = IP_IDLE;
          done_next  = 1'b1;
          level_next = rem_neg ? '0 : PCT_W'(LEVEL_MAX);
        end else begin
          state_next = IP_DIV;
        end
      end
      IP_DIV:   if (k == '0) state_next = IP_FIN;
      IP_FIN: begin
        state_next = IP_IDLE;
        done_next  = 1'b1;
        level_next = q_sat;
      end
      default:  state_next = IP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    level <= level_next;
    case (state)
      IP_IDLE: if (start) req_r <= req;
      IP_SPAN: begin
        num <= num_next;
        den <= den_next;
      end
      IP_MUL: begin
        prod_a <= PROD_W'(pp_s) * PROD_W'(den);
        prod_b <= PROD_W'(diff_s) * PROD_W'(num);
      end
      IP_SUM:   rem <= prod_a + prod_b;
      IP_RANGE: begin
        k <= K_W'(QUOT_W - 1);
        q <= '0;
      end
      IP_DIV: begin
        if (fit) begin
          rem  <= rem - trial;
          q[k] <= 1'b1;
        end
        if (k != '0) k <= k - 1'b1;
      end
      default: ;
    endcase
  end

endmodule

### sv/light_ramp_schedule_thermostat.sv
// Top level of the lamp, pump and heater controller: schedule memory, scan,
// mode and thermostat state, result register. Uses lrst_pkg and lrst_interp.
`timescale 1ns / 1ps

// Usage:
//   item channel (item_valid / item_stall / item): one command word per
//   transfer, func selects evaluate, mode button or schedule write.
//   result channel (result_valid / result_stall / result): exactly one word
//   per accepted item, in order.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   entry_count, index 1 is temp_setpoint; cfg_ready is always high, write
//   only while no item is in flight.
// Timing: one item at a time. An evaluation in automatic mode scans the
//   schedule memory through its single read port, one entry per cycle, then
//   runs a 7-step restoring divide; the divide is skipped when the span is
//   not positive or the quotient saturates. Writes, unused commands and
//   evaluations in the off and full modes skip the scan and go straight to
//   the result register. The next item is accepted the cycle after the
//   result loads.
// Reset: mode off, heater off, brightness 0, entry_count 1, setpoint 400;
//   schedule memory is not cleared and no item is stalled for it.
// Stall: the result register holds its word while result_stall is high; a new
//   item is still accepted and worked on, and waits for the register to free.
module light_ramp_schedule_thermostat (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  lrst_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output lrst_pkg::result_t          result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [lrst_pkg::CFG_W-1:0] cfg_data
);
  import lrst_pkg::*;

  ctrl_state_t state, state_next;

  logic [4:0]                entry_count;
  logic signed [TEMP_W-1:0]  temp_setpoint;
  logic [1:0]                mode_reg;
  logic                      heater_state;
  logic [PCT_W-1:0]          last_brightness;

  sched_entry_t              mem [MAX_ENTRIES];
  sched_entry_t              rd_data;
  logic                      rd_vld;
  logic [IDX_W-1:0]          rd_idx;
  logic [CNT_W-1:0]          cnt, n_eff;
  logic [IDX_W-1:0]          last_idx;

  logic [TIME_W-1:0]         now_r, t_prev, t_next, first_t, last_t, rd_t;
  logic [PCT_W-1:0]          p_prev, p_next, first_p, last_p;
  logic                      have_prev, have_next;

  logic                      accept, is_eval, to_scan, issue, load_out;
  logic [1:0]                mode_new;
  logic [CNT_W-1:0]          n_clamp;
  logic signed [TEMPX_W-1:0] temp_x, sp_hi, sp_lo;
  logic                      mem_we;

  interp_req_t               ip_req;
  logic                      ip_start, ip_done;
  logic [PCT_W-1:0]          ip_level;

  assign cfg_ready = 1'b1;

  always_comb begin
    accept   = (state == ST_IDLE) && item_valid;
    is_eval  = (item.func == FUNC_EVAL) || (item.func == FUNC_BUTTON);
    case (mode_reg)
      MODE_OFF:  mode_new = (item.func == FUNC_BUTTON) ? MODE_AUTO : mode_reg;
      MODE_AUTO: mode_new = (item.func == FUNC_BUTTON) ? MODE_FULL : mode_reg;
      default:   mode_new = (item.func == FUNC_BUTTON) ? MODE_OFF  : mode_reg;
    endcase
    to_scan  = is_eval && (mode_new == MODE_AUTO);
    mem_we   = accept && (item.func == FUNC_WRITE) && (32'(item.entry_index) < MAX_ENTRIES);
    if (entry_count == '0)
      n_clamp = CNT_W'(1);
    else if (32'(entry_count) > MAX_ENTRIES)
      n_clamp = CNT_W'(MAX_ENTRIES);
    else
      n_clamp = CNT_W'(entry_count);
    temp_x   = TEMPX_W'(item.temperature);
    sp_hi    = TEMPX_W'(temp_setpoint) + TEMPX_W'(HYST_STEPS);
    sp_lo    = TEMPX_W'(temp_setpoint) - TEMPX_W'(HYST_STEPS);
    last_idx = IDX_W'(n_eff - 1'b1);
    issue    = (state == ST_SCAN) && (cnt < n_eff);
    rd_t     = point_time(rd_data.hour, rd_data.minute);
    load_out = (state == ST_DONE) && (!result_valid || !result_stall);
    ip_start = (state == ST_START);
    ip_req.now    = now_r;
    ip_req.t_prev = have_prev ? t_prev : last_t;
    ip_req.p_prev = have_prev ? p_prev : last_p;
    ip_req.t_next = have_next ? t_next : first_t;
    ip_req.p_next = have_next ? p_next : first_p;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    item_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE:   if (item_valid) state_next = to_scan ? ST_SCAN : ST_DONE;
      ST_SCAN:   if (rd_vld && (rd_idx == last_idx)) state_next = ST_START;
      ST_START:  state_next = ST_INTERP;
      ST_INTERP: if (ip_done) state_next = ST_DONE;
      ST_DONE:   if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // configuration and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= 5'd1;
      temp_setpoint   <= TEMP_W'(400);
      mode_reg        <= MODE_OFF;
      heater_state    <= 1'b0;
      last_brightness <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENTRY_COUNT:   entry_count   <= cfg_data[4:0];
          CFG_TEMP_SETPOINT: temp_setpoint <= $signed(cfg_data[TEMP_W-1:0]);
          default: ;
        endcase
      end
      if (accept && is_eval) begin
        mode_reg <= mode_new;
        if (mode_new == MODE_AUTO) begin
          if ((temp_x > sp_hi) || item.sensor_disconnected)
            heater_state <= 1'b0;
          else if (temp_x < sp_lo)
            heater_state <= 1'b1;
        end else begin
          heater_state    <= 1'b0;
          last_brightness <= (mode_new == MODE_FULL) ? PCT_W'(LEVEL_MAX) : '0;
        end
      end
      if ((state == ST_INTERP) && ip_done) last_brightness <= ip_level;
    end
  end

  // schedule memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IDX_W'(item.entry_index)] <= '{hour: item.entry_hour,
                                         minute: item.entry_minute,
                                         percent: item.entry_percent};
    end
    rd_data <= mem[cnt[IDX_W-1:0]];
    rd_idx  <= cnt[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_vld <= 1'b0;
    else     rd_vld <= issue;
  end

  // scan: last point at or before now, first point after now
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r     <= point_time(item.hour, item.minute);
      n_eff     <= n_clamp;
      cnt       <= '0;
      have_prev <= 1'b0;
      have_next <= 1'b0;
    end else begin
      if (issue) cnt <= cnt + 1'b1;
      if (rd_vld) begin
        if (now_r >= rd_t) begin
          have_prev <= 1'b1;
          t_prev    <= rd_t;
          p_prev    <= rd_data.percent;
        end
        if (!have_next && (now_r < rd_t)) begin
          have_next <= 1'b1;
          t_next    <= rd_t;
          p_next    <= rd_data.percent;
        end
        if (rd_idx == '0) begin
          first_t <= rd_t;
          first_p <= rd_data.percent;
        end
        if (rd_idx == last_idx) begin
          last_t <= rd_t;
          last_p <= rd_data.percent;
        end
      end
    end
  end

  lrst_interp u_interp (
    .clk   (clk),
    .rst   (rst),
    .start (ip_start),
    .req   (ip_req),
    .done  (ip_done),
    .level (ip_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.mode          <= mode_reg;
      result.light_percent <= last_brightness;
      result.pump_on       <= (mode_reg == MODE_AUTO);
      result.heater_on     <= heater_state;
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state != ST_IDLE))
    else $error("item accepted but controller stayed idle");

  a_heater_auto: assert property (@(posedge clk) disable iff (rst)
    heater_state |-> (mode_reg == MODE_AUTO))
    else $error("heater on outside automatic mode");

  a_level_max: assert property (@(posedge clk) disable iff (rst)
    last_brightness <= PCT_W'(LEVEL_MAX))
    else $error("brightness above full scale");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (state == ST_SCAN))
    else $error("schedule read returned outside scan");

  a_done_in_interp: assert property (@(posedge clk) disable iff (rst)
    ip_done |-> (state == ST_INTERP))
    else $error("interpolator finished while not awaited");
`endif

endmodule
